// ===== hw/rtl/tsq_pkg.sv =====
// Shared types and codes for the two-stack queue.
package tsq_pkg;

    // Result status codes
    typedef logic [1:0] tsq_status_t;
    localparam tsq_status_t STAT_ENQUEUED = 2'd0;
    localparam tsq_status_t STAT_DEQUEUED = 2'd1;
    localparam tsq_status_t STAT_EMPTY    = 2'd2;
    localparam tsq_status_t STAT_OVERFLOW = 2'd3;

    // Source of the result value
    typedef logic [1:0] tsq_res_sel_t;
    localparam tsq_res_sel_t RES_ZERO   = 2'd0;
    localparam tsq_res_sel_t RES_NEG1   = 2'd1;
    localparam tsq_res_sel_t RES_IN_RD  = 2'd2;
    localparam tsq_res_sel_t RES_OUT_RD = 2'd3;

    // Input actions
    localparam logic ACT_ENQUEUE = 1'b0;
    localparam logic ACT_DEQUEUE = 1'b1;

    localparam int unsigned VALUE_W = 32;
    typedef logic signed [VALUE_W-1:0] tsq_value_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic         push_in;   // write input word on input stack
        logic         pop_in;    // read input stack top, shrink it
        logic         push_out;  // write input-stack read word on output stack
        logic         pop_out;   // read output stack top, shrink it
        logic         load_res;  // fill the output register
        tsq_res_sel_t res_sel;
        tsq_status_t  res_status;
    } tsq_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic in_empty;
        logic in_full;
        logic out_empty;
        logic res_free;  // output register can take a word this cycle
    } tsq_stat_t;

endpackage

// ===== hw/rtl/two_stack_queue.sv =====
// Enqueue, overflow and empty-dequeue results are registered and appear in the cycle after accept.
// A dequeue from a non-empty output stack reads the stack top into a register, then loads the output register.
// A dequeue that refills the output stack moves input-stack words one word per cycle.
// The next word is accepted once the result sits in the output register and can be taken.
// Reset clears stack counts, controller state and output valid; stack memories keep contents.
module two_stack_queue #(
    parameter int unsigned STACK_DEPTH = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  tsq_pkg::tsq_value_t s_tdata,   // [31:0] value_in
    input  logic                s_tuser,   // [0] action
    output logic                m_tvalid,
    input  logic                m_tready,
    output tsq_pkg::tsq_value_t m_tdata,   // [31:0] value_out
    output tsq_pkg::tsq_status_t m_tuser   // [1:0] status
);
    import tsq_pkg::*;

    tsq_cmd_t  cmd;
    tsq_stat_t stat;

    tsq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .action   (s_tuser),
        .stat     (stat),
        .cmd      (cmd)
    );

    tsq_datapath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .value_in  (s_tdata),
        .value_out (m_tdata),
        .status    (m_tuser),
        .res_valid (m_tvalid),
        .res_ready (m_tready)
    );

endmodule

// ===== hw/rtl/tsq_datapath.sv =====
// Datapath of the two-stack queue: stack memories, counts and output register.
module tsq_datapath #(
    parameter int unsigned STACK_DEPTH = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  tsq_pkg::tsq_cmd_t  cmd,
    output tsq_pkg::tsq_stat_t stat,
    input  tsq_pkg::tsq_value_t value_in,
    output tsq_pkg::tsq_value_t value_out,
    output tsq_pkg::tsq_status_t status,
    output logic               res_valid,
    input  logic               res_ready
);
    import tsq_pkg::*;

    localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
    localparam logic [CW-1:0] CNT_ONE  = CW'(1);
    localparam logic [CW-1:0] CNT_FULL = CW'(STACK_DEPTH);

    logic [VALUE_W-1:0] in_mem  [STACK_DEPTH];
    logic [VALUE_W-1:0] out_mem [STACK_DEPTH];

    logic [CW-1:0] in_cnt_reg, in_cnt_next;
    logic [CW-1:0] out_cnt_reg, out_cnt_next;
    logic [CW-1:0] in_dec, out_dec;
    logic [VALUE_W-1:0] in_rd_reg;
    logic [VALUE_W-1:0] out_rd_reg;
    tsq_value_t  res_value_reg, res_value_next;
    tsq_status_t res_status_reg;
    logic        res_valid_reg, res_valid_next;

    assign in_dec  = in_cnt_reg - CNT_ONE;
    assign out_dec = out_cnt_reg - CNT_ONE;

    // Input stack: one write or one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (cmd.push_in)
        begin
            in_mem[in_cnt_reg[AW-1:0]] <= value_in;
        end
        if (cmd.pop_in)
        begin
            in_rd_reg <= in_mem[in_dec[AW-1:0]];
        end
    end

    // Output stack: fed from the input-stack read word
    always_ff @(posedge clk)
    begin
        if (cmd.push_out)
        begin
            out_mem[out_cnt_reg[AW-1:0]] <= in_rd_reg;
        end
        if (cmd.pop_out)
        begin
            out_rd_reg <= out_mem[out_dec[AW-1:0]];
        end
    end

    // Advance the stack counts
    always_comb
    begin
        in_cnt_next  = in_cnt_reg;
        out_cnt_next = out_cnt_reg;
        if (cmd.push_in)
        begin
            in_cnt_next = in_cnt_reg + CNT_ONE;
        end
        else if (cmd.pop_in)
        begin
            in_cnt_next = in_dec;
        end
        if (cmd.push_out)
        begin
            out_cnt_next = out_cnt_reg + CNT_ONE;
        end
        else if (cmd.pop_out)
        begin
            out_cnt_next = out_dec;
        end
    end

    // Pick the result word
    always_comb
    begin
        unique case (cmd.res_sel)
            RES_ZERO:   res_value_next = '0;
            RES_NEG1:   res_value_next = '1;
            RES_IN_RD:  res_value_next = in_rd_reg;
            RES_OUT_RD: res_value_next = out_rd_reg;
            default:    res_value_next = '0;
        endcase
    end

    // Hold the output word until it is taken
    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (res_ready)
        begin
            res_valid_next = 1'b0;
        end
        if (cmd.load_res)
        begin
            res_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_cnt_reg    <= '0;
            out_cnt_reg   <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            in_cnt_reg    <= in_cnt_next;
            out_cnt_reg   <= out_cnt_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_res)
        begin
            res_value_reg  <= res_value_next;
            res_status_reg <= cmd.res_status;
        end
    end

    assign stat.in_empty  = (in_cnt_reg == '0);
    assign stat.in_full   = (in_cnt_reg == CNT_FULL);
    assign stat.out_empty = (out_cnt_reg == '0);
    assign stat.res_free  = !res_valid_reg || res_ready;

    assign value_out = res_value_reg;
    assign status    = res_status_reg;
    assign res_valid = res_valid_reg;

endmodule

// ===== hw/rtl/tsq_ctrl.sv =====
// Controller of the two-stack queue: sequences push, pop and stack transfer.
module tsq_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               action,
    input  tsq_pkg::tsq_stat_t stat,
    output tsq_pkg::tsq_cmd_t  cmd
);
    import tsq_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_POP  = 2'd1;
    localparam logic [1:0] S_XFER = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       accept;

    assign in_ready = (state_reg == S_IDLE) && stat.res_free;
    assign accept   = in_valid && in_ready;

    // Decode the next step
    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        cmd.res_sel    = RES_ZERO;
        cmd.res_status = STAT_ENQUEUED;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (action == ACT_ENQUEUE)
                    begin
                        cmd.load_res = 1'b1;
                        cmd.res_sel  = RES_ZERO;
                        if (stat.in_full)
                        begin
                            cmd.res_status = STAT_OVERFLOW;
                        end
                        else
                        begin
                            cmd.push_in    = 1'b1;
                            cmd.res_status = STAT_ENQUEUED;
                        end
                    end
                    else if (!stat.out_empty)
                    begin
                        cmd.pop_out = 1'b1;
                        state_next  = S_POP;
                    end
                    else if (stat.in_empty)
                    begin
                        cmd.load_res   = 1'b1;
                        cmd.res_sel    = RES_NEG1;
                        cmd.res_status = STAT_EMPTY;
                    end
                    else
                    begin
                        cmd.pop_in = 1'b1;
                        state_next = S_XFER;
                    end
                end
            end
            S_POP:
            begin
                cmd.load_res   = 1'b1;
                cmd.res_sel    = RES_OUT_RD;
                cmd.res_status = STAT_DEQUEUED;
                state_next     = S_IDLE;
            end
            S_XFER:
            begin
                // The oldest word comes out last: hand it straight to the output
                if (stat.in_empty)
                begin
                    cmd.load_res   = 1'b1;
                    cmd.res_sel    = RES_IN_RD;
                    cmd.res_status = STAT_DEQUEUED;
                    state_next     = S_IDLE;
                end
                else
                begin
                    cmd.push_out = 1'b1;
                    cmd.pop_in   = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== bench/tb_two_stack_queue.sv =====
// Self-checking testbench for the two-stack queue: directed table, then random traffic.
module tb_two_stack_queue;

    import tsq_pkg::*;

    localparam int unsigned STACK_DEPTH  = 16;
    localparam int          RANDOM_WORDS = 1920;
    localparam int          PAUSE_AT     = 1200;  // sender waits here until every result is back
    localparam int          CALM_FROM    = RANDOM_WORDS - 250;
    localparam int          HOLD_AT      = 700;   // receiver starts its long hold-off here
    localparam int          HOLD_CYCLES  = 300;
    localparam int          TAIL_CYCLES  = 24;
    localparam int          RUN_LIMIT    = 12 * 600000;

    localparam tsq_value_t EMPTY_VALUE = -1;
    localparam tsq_value_t ZERO_VALUE  = '0;
    localparam tsq_value_t MAX_VALUE   = 32'sh7fff_ffff;
    localparam tsq_value_t MIN_VALUE   = 32'sh8000_0000;

    typedef struct packed {
        tsq_value_t  value;
        tsq_status_t status;
    } queue_result_t;

    // One directed row; repeated rows step the value by one per word
    typedef struct packed {
        logic        act;
        tsq_value_t  val;
        int          reps;
        logic        typed;
        tsq_value_t  exp_value;
        tsq_status_t exp_status;
    } stim_row_t;

    localparam int DIRECTED_ROWS = 14;

    stim_row_t directed_rows [0:DIRECTED_ROWS-1] = '{
        '{ACT_DEQUEUE, ZERO_VALUE,        1,  1'b1, EMPTY_VALUE, STAT_EMPTY},
        '{ACT_ENQUEUE, MAX_VALUE,         1,  1'b1, ZERO_VALUE,  STAT_ENQUEUED},
        '{ACT_ENQUEUE, MIN_VALUE,         1,  1'b1, ZERO_VALUE,  STAT_ENQUEUED},
        '{ACT_DEQUEUE, ZERO_VALUE,        1,  1'b0, ZERO_VALUE,  STAT_DEQUEUED},
        '{ACT_ENQUEUE, ZERO_VALUE,        1,  1'b1, ZERO_VALUE,  STAT_ENQUEUED},
        '{ACT_ENQUEUE, EMPTY_VALUE,       1,  1'b1, ZERO_VALUE,  STAT_ENQUEUED},
        '{ACT_DEQUEUE, MAX_VALUE,         1,  1'b0, ZERO_VALUE,  STAT_DEQUEUED},
        '{ACT_DEQUEUE, ZERO_VALUE,        1,  1'b0, ZERO_VALUE,  STAT_DEQUEUED},
        '{ACT_DEQUEUE, ZERO_VALUE,        1,  1'b0, ZERO_VALUE,  STAT_DEQUEUED},
        '{ACT_DEQUEUE, ZERO_VALUE,        1,  1'b1, EMPTY_VALUE, STAT_EMPTY},
        '{ACT_ENQUEUE, 32'sh5a5a_0000,    16, 1'b1, ZERO_VALUE,  STAT_ENQUEUED},
        '{ACT_ENQUEUE, 32'sh1234_5678,    1,  1'b1, ZERO_VALUE,  STAT_OVERFLOW},
        '{ACT_DEQUEUE, 32'sha5a5_a5a5,    1,  1'b0, ZERO_VALUE,  STAT_DEQUEUED},
        '{ACT_ENQUEUE, 32'sh0f0f_0f0f,    1,  1'b0, ZERO_VALUE,  STAT_ENQUEUED}
    };

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    tsq_value_t  s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    tsq_value_t  m_tdata;
    tsq_status_t m_tuser;

    // Predictor state: push side, pop side and their fill levels
    tsq_value_t push_side [0:STACK_DEPTH-1];
    tsq_value_t pop_side  [0:STACK_DEPTH-1];
    int         push_depth = 0;
    int         pop_depth  = 0;

    queue_result_t pending_results [$];
    queue_result_t pinned_results  [$];
    logic          pinned_typed    [$];

    int  mismatch_count = 0;
    int  words_in       = 0;
    int  words_out      = 0;
    int  words_sent     = 0;
    int  status_seen [0:3] = '{0, 0, 0, 0};
    int  transfers      = 0;
    int  full_transfers = 0;
    bit  calm           = 1'b0;

    two_stack_queue #(
        .STACK_DEPTH(STACK_DEPTH)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // [31:0] value_in
        .s_tuser  (s_tuser),   // [0] action
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // [31:0] value_out
        .m_tuser  (m_tuser)    // [1:0] status
    );

    always #6 clk = ~clk;

    // Work out the result of one word and advance the predictor state
    function automatic queue_result_t predict_queue_result(logic act, tsq_value_t val);
        queue_result_t res;
        res.value  = ZERO_VALUE;
        res.status = STAT_ENQUEUED;
        if (act == ACT_ENQUEUE) begin
            if (push_depth >= STACK_DEPTH)
                res.status = STAT_OVERFLOW;
            else begin
                push_side[push_depth] = val;
                push_depth++;
            end
        end
        else if (pop_depth == 0 && push_depth == 0) begin
            res.value  = EMPTY_VALUE;
            res.status = STAT_EMPTY;
        end
        else begin
            // Refill the pop side in reverse order when it has run dry
            if (pop_depth == 0) begin
                transfers++;
                if (push_depth == STACK_DEPTH)
                    full_transfers++;
                while (push_depth > 0) begin
                    push_depth--;
                    pop_side[pop_depth] = push_side[push_depth];
                    pop_depth++;
                end
            end
            pop_depth--;
            res.value  = pop_side[pop_depth];
            res.status = STAT_DEQUEUED;
        end
        return res;
    endfunction

    // Offer one word, with an optional idle burst first, and hold it until taken
    task automatic send_word(input logic act, input tsq_value_t val);
        int gap;
        if (!calm && ((words_in / 150) % 3 != 2) && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 6);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= val;
        do @(posedge clk); while (!s_tready);
        words_sent++;
    endtask

    // Track accepted words on both sides and check results in order
    always @(posedge clk) begin
        queue_result_t predicted;
        queue_result_t want;
        logic          typed;
        if (m_tvalid && m_tready) begin
            words_out++;
            status_seen[m_tuser]++;
            if (pending_results.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected result, actual value %h status %0d",
                         $time, m_tdata, m_tuser);
            end
            else begin
                want = pending_results.pop_front();
                if (m_tdata !== want.value) begin
                    mismatch_count++;
                    $display("%0t: value_out mismatch, expected %h, actual %h",
                             $time, want.value, m_tdata);
                end
                if (m_tuser !== want.status) begin
                    mismatch_count++;
                    $display("%0t: status mismatch, expected %0d, actual %0d",
                             $time, want.status, m_tuser);
                end
            end
        end
        if (s_tvalid && s_tready) begin
            words_in++;
            predicted = predict_queue_result(s_tuser, s_tdata);
            // Directed rows with a hand-written answer take precedence
            if (pinned_typed.size() != 0) begin
                typed = pinned_typed.pop_front();
                want  = pinned_results.pop_front();
                if (typed)
                    predicted = want;
            end
            pending_results.push_back(predicted);
        end
    end

    // Receiver: random stall bursts, one long hold-off, steady toward the end
    initial begin
        int  burst;
        bit  held;
        held = 1'b0;
        m_tready <= 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            @(posedge clk);
            if (!held && words_in >= HOLD_AT) begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge clk);
            end
            else if (!calm && ((words_out / 150) % 3 != 1) && $urandom_range(0, 3) == 0) begin
                burst = $urandom_range(1, 6);
                m_tready <= 1'b0;
                repeat (burst - 1) @(posedge clk);
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Sender: reset, directed table, random traffic, drain and report
    initial begin
        int         row;
        int         rep;
        int         issued;
        int         seg_len;
        int         enq_pct;
        int         k;
        logic       act;
        tsq_value_t val;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= ZERO_VALUE;
        s_tuser  <= ACT_ENQUEUE;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Walk the directed table
        for (row = 0; row < DIRECTED_ROWS; row++) begin
            for (rep = 0; rep < directed_rows[row].reps; rep++) begin
                pinned_typed.push_back(directed_rows[row].typed);
                pinned_results.push_back('{directed_rows[row].exp_value,
                                           directed_rows[row].exp_status});
                send_word(directed_rows[row].act, directed_rows[row].val + rep);
            end
        end

        // Random segments with shifting enqueue bias to hit full and empty stacks
        issued = 0;
        while (issued < RANDOM_WORDS) begin
            seg_len = $urandom_range(8, 64);
            case ($urandom_range(0, 3))
                0:       enq_pct = 15;
                1:       enq_pct = 50;
                2:       enq_pct = 70;
                default: enq_pct = 92;
            endcase
            for (k = 0; k < seg_len && issued < RANDOM_WORDS; k++) begin
                act = ($urandom_range(0, 99) < enq_pct) ? ACT_ENQUEUE : ACT_DEQUEUE;
                val = $urandom;
                case ($urandom_range(0, 9))
                    0:       val = MAX_VALUE;
                    1:       val = MIN_VALUE;
                    2:       val = ZERO_VALUE;
                    3:       val = EMPTY_VALUE;
                    default: ;
                endcase
                send_word(act, val);
                issued++;
                if (issued == CALM_FROM)
                    calm = 1'b1;
                // Hold off the sender until every result is back
                if (issued == PAUSE_AT) begin
                    s_tvalid <= 1'b0;
                    while (words_out < words_sent) @(posedge clk);
                end
            end
        end
        s_tvalid <= 1'b0;

        // Drain, then watch for stray results
        while (words_out < words_sent) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Sent %0d words, checked %0d results: %0d enqueued, %0d dequeued, %0d empty,",
                 words_in, words_out, status_seen[STAT_ENQUEUED], status_seen[STAT_DEQUEUED],
                 status_seen[STAT_EMPTY]);
        $display("%0d overflow drops; %0d stack transfers, %0d of them at full depth.",
                 status_seen[STAT_OVERFLOW], transfers, full_transfers);
        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Guard against a hung handshake
    initial begin
        #(RUN_LIMIT);
        $display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
        $display("DONE: errors detected");
        $finish;
    end

endmodule
